// ===== rtl/grayscale_block_mean_to_glyph_macros.svh =====
// Assertion macros used by the top level of the glyph generator RTL.
`ifndef GRAYSCALE_BLOCK_MEAN_TO_GLYPH_MACROS_SVH
`define GRAYSCALE_BLOCK_MEAN_TO_GLYPH_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define GBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define GBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gbm_pkg.sv =====
// Shared constants, types and lookup tables of the block-mean glyph generator.
package gbm_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 13;
  localparam int COL_W       = 10;
  localparam int ROW_W       = 12;
  localparam int SUM_DEPTH   = MAX_WIDTH / 2;
  localparam int ADDR_W      = $clog2(SUM_DEPTH);
  localparam int PIX_W       = 8;
  localparam int DELTA_W     = PIX_W + 1;
  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;
  localparam int RECIP_W     = 17;
  localparam int FRAC_SHIFT  = 16;
  localparam int LEVEL_SHIFT = 4;
  localparam int LEVEL_W     = 4;
  localparam int GLYPH_W     = 7;
  localparam int QDEPTH      = 8;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = HEIGHT_W;
  localparam int OUT_DATA_W  = 16;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // One accepted pixel, as it goes to the sum memories.
  typedef struct packed {
    logic               vld;
    logic [ADDR_W-1:0]  addr;
    logic [DELTA_W-1:0] delta;
    logic               cur_bank;
    logic               wr_next;
    logic               emit;
    logic [CNT_W-1:0]   pixels;
    logic               line_end;
    logic               frame_end;
  } pix_item_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } clr_cmd_t;

  typedef struct packed {
    logic             vld;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] pixels;
    logic             line_end;
    logic             frame_end;
  } sum_res_t;

  typedef struct packed {
    logic               frame_end;
    logic               line_end;
    logic [LEVEL_W-1:0] level;
    logic [GLYPH_W-1:0] glyph;
  } glyph_item_t;

  // ceil(2^16 / n): exact floor division for sums below 4096.
  function automatic logic [RECIP_W-1:0] recip_lut(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      4'd10:   r = 17'd6554;
      4'd11:   r = 17'd5958;
      4'd12:   r = 17'd5462;
      4'd13:   r = 17'd5042;
      4'd14:   r = 17'd4682;
      4'd15:   r = 17'd4370;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Glyph ramp from darkest to brightest: " .,:;-~=+^*#%8$@".
  function automatic logic [GLYPH_W-1:0] glyph_lut(input logic [LEVEL_W-1:0] lvl);
    logic [GLYPH_W-1:0] g;
    case (lvl)
      4'd0:    g = 7'd32;
      4'd1:    g = 7'd46;
      4'd2:    g = 7'd44;
      4'd3:    g = 7'd58;
      4'd4:    g = 7'd59;
      4'd5:    g = 7'd45;
      4'd6:    g = 7'd126;
      4'd7:    g = 7'd61;
      4'd8:    g = 7'd43;
      4'd9:    g = 7'd94;
      4'd10:   g = 7'd42;
      4'd11:   g = 7'd35;
      4'd12:   g = 7'd37;
      4'd13:   g = 7'd56;
      4'd14:   g = 7'd36;
      4'd15:   g = 7'd64;
      default: g = 7'd32;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/grayscale_block_mean_to_glyph.sv =====
// A window's result passes the s1_r register, the s2 and s3 registers and the output queue to out_.
// Throughput: one pixel per cycle; each pixel does one read-modify-write of the sum memories.
// Input stalls while clearing or when the 8-entry output queue could not take results in flight.
// Reset and any configuration write restart the frame and start a clearing pass over all 512 entries
// of both sum memories, one entry per cycle, during which in_tready stays low.
`include "grayscale_block_mean_to_glyph_macros.svh"
module grayscale_block_mean_to_glyph
  import gbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,    // [7:0] pixel_value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [6:0] glyph_code, [10:7] level, [15:11] zero
  output logic                  out_tlast,   // line_end
  output logic                  out_tuser,   // [0] frame_end
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  pix_item_t   item;
  clr_cmd_t    clr;
  sum_res_t    res;
  glyph_item_t out_item;
  logic        room;

  gbm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .pixel_value (in_tdata),
    .room        (room),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .clr         (clr)
  );

  gbm_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .clr   (clr),
    .res   (res)
  );

  gbm_quant u_quant (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_item   (out_item)
  );

  assign out_tdata = {(OUT_DATA_W - LEVEL_W - GLYPH_W)'(0), out_item.level, out_item.glyph};
  assign out_tlast = out_item.line_end;
  assign out_tuser = out_item.frame_end;

  `GBM_ASSERT_NOW(a_clear_blocks_input, clr.en, !in_tready, "pixel taken during memory clear")
  `GBM_ASSERT_NEXT(a_cfg_starts_clear, cfg_wr_en, clr.en && (clr.addr == '0),
                   "configuration write did not restart the clearing pass")
  `GBM_ASSERT_NOW(a_frame_end_on_line_end, out_tvalid && out_tuser, out_tlast,
                  "frame end flagged on a result that does not end its line")

endmodule

// ===== rtl/gbm_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
module gbm_ram #(
  parameter int DEPTH  = 512,
  parameter int DATA_W = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gbm_ctrl.sv =====
// Configuration registers, raster counters, window addressing and memory clear sequencing.
module gbm_ctrl
  import gbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      pixel_value,
  input  logic                  room,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  output pix_item_t             item,
  output clr_cmd_t              clr
);

  logic [WIDTH_W-1:0]  width_r, width_nxt;
  logic [HEIGHT_W-1:0] height_r, height_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic                sel_r, sel_nxt;
  logic [PIX_W-1:0]    carry_r, carry_nxt;
  logic                clr_en_r, clr_en_nxt;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;

  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic                accept;
  logic                last_col;
  logic                last_row;
  logic                band_end;
  logic [2:0]          rows_n;
  logic [1:0]          cols_n;
  logic [4:0]          pix_prod;
  logic [DELTA_W-1:0]  delta;

  assign w_eff = (width_r == '0) ? WIDTH_W'(1) :
                 (width_r > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_r;
  assign h_eff = (height_r == '0) ? HEIGHT_W'(1) :
                 (height_r > HEIGHT_W'(MAX_HEIGHT)) ? HEIGHT_W'(MAX_HEIGHT) : height_r;

  assign in_tready = !clr_en_r && room;
  assign accept    = in_tvalid && in_tready;

  assign last_col = ({1'b0, col_r} + WIDTH_W'(1)) >= w_eff;
  assign last_row = ({1'b0, row_r} + HEIGHT_W'(1)) >= h_eff;
  assign band_end = (row_r[1:0] == 2'd3);

  // Window extent: the first band and the first column pair have no row or column above/left.
  assign rows_n   = (row_r[ROW_W-1:2] == '0) ? ({1'b0, row_r[1:0]} + 3'd1)
                                             : ({1'b0, row_r[1:0]} + 3'd2);
  assign cols_n   = (col_r[COL_W-1:1] == '0) ? ({1'b0, col_r[0]} + 2'd1)
                                             : ({1'b0, col_r[0]} + 2'd2);
  assign pix_prod = 5'(rows_n) * 5'(cols_n);

  // An odd column also belongs to the next window; it is added together with the even
  // column that follows, so that each pixel updates one address in one or both sum memories.
  assign delta = (col_r[0] || (col_r == '0)) ? {1'b0, pixel_value}
                                             : ({1'b0, pixel_value} + {1'b0, carry_r});

  always_comb begin
    item.vld       = accept;
    item.addr      = col_r[COL_W-1:1];
    item.delta     = delta;
    item.cur_bank  = sel_r;
    item.wr_next   = band_end && !last_row;
    item.emit      = (band_end || last_row) && (col_r[0] || last_col);
    item.pixels    = pix_prod[CNT_W-1:0];
    item.line_end  = last_col;
    item.frame_end = last_col && last_row;
  end

  assign clr.en   = clr_en_r;
  assign clr.addr = clr_addr_r;

  always_comb begin
    width_nxt    = width_r;
    height_nxt   = height_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    sel_nxt      = sel_r;
    carry_nxt    = carry_r;
    clr_en_nxt   = clr_en_r;
    clr_addr_nxt = clr_addr_r;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  width_nxt  = cfg_wr_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_nxt = cfg_wr_data[HEIGHT_W-1:0];
        default: ;
      endcase
      col_nxt      = '0;
      row_nxt      = '0;
      sel_nxt      = 1'b0;
      clr_en_nxt   = 1'b1;
      clr_addr_nxt = '0;
    end else begin
      if (clr_en_r) begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == '1) begin
          clr_en_nxt = 1'b0;
        end
      end
      if (accept) begin
        if (col_r[0]) begin
          carry_nxt = pixel_value;
        end
        if (last_col) begin
          col_nxt = '0;
          if (last_row) begin
            row_nxt = '0;
          end else begin
            row_nxt = row_r + ROW_W'(1);
            // The next band's partial sums become the current ones.
            if (band_end) begin
              sel_nxt = !sel_r;
            end
          end
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
    if (!rst_n) begin
      width_r    <= WIDTH_RESET;
      height_r   <= HEIGHT_RESET;
      col_r      <= '0;
      row_r      <= '0;
      sel_r      <= 1'b0;
      clr_en_r   <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      sel_r      <= sel_nxt;
      clr_en_r   <= clr_en_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

endmodule

// ===== rtl/gbm_accum.sv =====
// Read-modify-write of the two band sum memories with write forwarding.
module gbm_accum
  import gbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  pix_item_t item,
  input  clr_cmd_t  clr,
  output sum_res_t  res
);

  pix_item_t         s1_r;
  logic [1:0]        fw_vld_r;
  logic [ADDR_W-1:0] fw_addr_r;
  logic [SUM_W-1:0]  fw_data_r [2];

  logic [SUM_W-1:0]  rd_data [2];
  logic [SUM_W-1:0]  q_data [2];
  logic [1:0]        we;
  logic [SUM_W-1:0]  wdata [2];
  logic [ADDR_W-1:0] waddr;
  logic [SUM_W-1:0]  cur_old, nxt_old, cur_new, nxt_new, cur_wr;

  for (genvar b = 0; b < 2; b++) begin : g_bank
    gbm_ram #(
      .DEPTH  (SUM_DEPTH),
      .DATA_W (SUM_W)
    ) u_ram (
      .clk   (clk),
      .we    (we[b]),
      .waddr (waddr),
      .wdata (wdata[b]),
      .re    (item.vld),
      .raddr (item.addr),
      .rdata (rd_data[b])
    );

    // A write in the previous cycle is not yet visible in the registered read data.
    assign q_data[b] = (fw_vld_r[b] && (fw_addr_r == s1_r.addr)) ? fw_data_r[b] : rd_data[b];
  end

  assign cur_old = s1_r.cur_bank ? q_data[1] : q_data[0];
  assign nxt_old = s1_r.cur_bank ? q_data[0] : q_data[1];
  assign cur_new = cur_old + SUM_W'(s1_r.delta);
  assign nxt_new = nxt_old + SUM_W'(s1_r.delta);
  // A window's entry is read out exactly once per band, so it is zeroed there and is
  // clean when its bank takes the role of the next band.
  assign cur_wr  = s1_r.emit ? '0 : cur_new;

  always_comb begin
    waddr = clr.en ? clr.addr : s1_r.addr;
    if (clr.en) begin
      we       = 2'b11;
      wdata[0] = '0;
      wdata[1] = '0;
    end else begin
      we[0]    = s1_r.vld && (!s1_r.cur_bank || s1_r.wr_next);
      we[1]    = s1_r.vld && (s1_r.cur_bank || s1_r.wr_next);
      wdata[0] = s1_r.cur_bank ? nxt_new : cur_wr;
      wdata[1] = s1_r.cur_bank ? cur_wr : nxt_new;
    end
  end

  always_comb begin
    res.vld       = s1_r.vld && s1_r.emit;
    res.sum       = cur_new;
    res.pixels    = s1_r.pixels;
    res.line_end  = s1_r.line_end;
    res.frame_end = s1_r.frame_end;
  end

  always_ff @(posedge clk) begin
    s1_r         <= item;
    fw_addr_r    <= s1_r.addr;
    fw_data_r[0] <= wdata[0];
    fw_data_r[1] <= wdata[1];
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      fw_vld_r <= '0;
    end else begin
      fw_vld_r <= clr.en ? 2'b00 : we;
    end
  end

endmodule

// ===== rtl/gbm_quant.sv =====
// Mean by reciprocal multiply, level and glyph lookup, and the output queue.
module gbm_quant
  import gbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  sum_res_t    res,
  output logic        room,
  output logic        out_tvalid,
  input  logic        out_tready,
  output glyph_item_t out_item
);

  logic                     s2_vld_r;
  logic [SUM_W-1:0]         s2_sum_r;
  logic [RECIP_W-1:0]       s2_recip_r;
  logic                     s2_line_r, s2_frame_r;
  logic                     s3_vld_r;
  logic [LEVEL_W-1:0]       s3_level_r;
  logic                     s3_line_r, s3_frame_r;

  glyph_item_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]        wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]          cnt_r, cnt_nxt;
  logic [QPTR_W+1:0]        pending;
  logic [SUM_W+RECIP_W-1:0] prod;
  glyph_item_t              push_item;
  logic                     pop;

  assign prod = s2_sum_r * s2_recip_r;

  // Every result already in flight must find a queue slot, plus the one a new pixel may add.
  assign pending = (QPTR_W+2)'(cnt_r) + (QPTR_W+2)'(s2_vld_r) + (QPTR_W+2)'(s3_vld_r)
                 + (QPTR_W+2)'(res.vld);
  assign room    = pending < (QPTR_W+2)'(QDEPTH);

  always_comb begin
    push_item.frame_end = s3_frame_r;
    push_item.line_end  = s3_line_r;
    push_item.level     = s3_level_r;
    push_item.glyph     = glyph_lut(s3_level_r);
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_item   = q_mem_r[rd_ptr_r];
  assign pop        = out_tvalid && out_tready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (s3_vld_r && !pop) begin
      cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    end else if (!s3_vld_r && pop) begin
      cnt_nxt = cnt_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    s2_sum_r   <= res.sum;
    s2_recip_r <= recip_lut(res.pixels);
    s2_line_r  <= res.line_end;
    s2_frame_r <= res.frame_end;
    s3_level_r <= prod[FRAC_SHIFT+LEVEL_SHIFT +: LEVEL_W];
    s3_line_r  <= s2_line_r;
    s3_frame_r <= s2_frame_r;
    if (s3_vld_r) begin
      q_mem_r[wr_ptr_r] <= push_item;
    end
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      s2_vld_r <= res.vld;
      s3_vld_r <= s2_vld_r;
      cnt_r    <= cnt_nxt;
      if (s3_vld_r) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the block-mean glyph generator: streams pixel frames, checks each glyph.
module testbench;
  import gbm_pkg::*;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic [LEVEL_W-1:0] level;
    logic               line_end;
    logic               frame_end;
  } glyph_t;

  localparam int BANK_DEPTH = MAX_WIDTH / 2 + 1;
  localparam logic [8*16-1:0] GLYPH_RAMP = " .,:;-~=+^*#%8$@";
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PIXELS = 1550;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_wr_en = 1'b0;
  cfg_reg_t              cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  grayscale_block_mean_to_glyph u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),      // [7:0] pixel_value
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),     // [6:0] glyph_code, [10:7] level, [15:11] zero
    .out_tlast  (out_tlast),     // line_end
    .out_tuser  (out_tuser),     // [0] frame_end
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  // Glyph predictor state.
  logic [WIDTH_W-1:0]  model_width = WIDTH_RESET;
  logic [HEIGHT_W-1:0] model_height = HEIGHT_RESET;
  int unsigned         next_col;
  int unsigned         next_row;
  logic [SUM_W-1:0]    sums_cur [BANK_DEPTH];
  logic [SUM_W-1:0]    sums_next [BANK_DEPTH];
  glyph_t              expected_glyphs [$];

  int unsigned error_count = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_active = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL grayscale_block_mean_to_glyph");
    $finish;
  end

  function automatic void restart_frame();
    next_col = 0;
    next_row = 0;
    foreach (sums_cur[i]) begin
      sums_cur[i] = '0;
      sums_next[i] = '0;
    end
  endfunction

  function automatic int unsigned active_width(logic [WIDTH_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_WIDTH) return MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned active_height(logic [HEIGHT_W-1:0] h);
    if (h == 0) return 1;
    if (h > MAX_HEIGHT) return MAX_HEIGHT;
    return h;
  endfunction

  function automatic void add_to_window(bit to_next, int unsigned k, int unsigned v);
    if (k < BANK_DEPTH) begin
      if (to_next) sums_next[k] = sums_next[k] + SUM_W'(v);
      else sums_cur[k] = sums_cur[k] + SUM_W'(v);
    end
  endfunction

  function automatic void predict_pixel(logic [PIX_W-1:0] pix);
    int unsigned w, h, c, r, k, m, row_lo, col_lo, pixels, mean, lvl;
    bit last_col, last_row, band_end, spans_two;
    glyph_t g;
    w = active_width(model_width);
    h = active_height(model_height);
    c = next_col;
    r = next_row;
    k = c >> 1;
    last_col = (c + 1 >= w);
    last_row = (r + 1 >= h);
    band_end = ((r & 3) == 3);
    // An odd column sits on the border of two windows.
    spans_two = c[0] && (c + 1 < w);

    add_to_window(1'b0, k, pix);
    if (spans_two) add_to_window(1'b0, k + 1, pix);
    if (band_end) begin
      add_to_window(1'b1, k, pix);
      if (spans_two) add_to_window(1'b1, k + 1, pix);
    end

    if ((band_end || last_row) && (c[0] || last_col)) begin
      m = r >> 2;
      row_lo = (m == 0) ? 0 : 4 * m - 1;
      col_lo = (k == 0) ? 0 : 2 * k - 1;
      pixels = (r - row_lo + 1) * (c - col_lo + 1);
      mean = (k < BANK_DEPTH) ? sums_cur[k] / pixels : 0;
      lvl = (mean >> LEVEL_SHIFT) & 15;
      g.glyph = GLYPH_RAMP[8 * (15 - lvl) +: GLYPH_W];
      g.level = LEVEL_W'(lvl);
      g.line_end = last_col;
      g.frame_end = last_col && last_row;
      expected_glyphs.push_back(g);
    end

    if (last_col) begin
      if (last_row) begin
        restart_frame();
      end else begin
        if (band_end) begin
          foreach (sums_cur[i]) begin
            sums_cur[i] = sums_next[i];
            sums_next[i] = '0;
          end
        end
        next_col = 0;
        next_row = r + 1;
      end
    end else begin
      next_col = c + 1;
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    if (error_count <= 40)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // Output check comes before the input prediction of the same edge.
  always @(posedge clk) begin : scoreboard
    glyph_t want;
    if (!rst_n) begin
      model_width = WIDTH_RESET;
      model_height = HEIGHT_RESET;
      restart_frame();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_glyphs.size() == 0) begin
          report_mismatch("unexpected glyph", out_tdata[GLYPH_W-1:0], 0);
        end else begin
          want = expected_glyphs.pop_front();
          if (out_tdata[GLYPH_W-1:0] != want.glyph)
            report_mismatch("glyph_code", out_tdata[GLYPH_W-1:0], want.glyph);
          if (out_tdata[GLYPH_W +: LEVEL_W] != want.level)
            report_mismatch("level", out_tdata[GLYPH_W +: LEVEL_W], want.level);
          if (out_tlast != want.line_end)
            report_mismatch("line_end", out_tlast, want.line_end);
          if (out_tuser != want.frame_end)
            report_mismatch("frame_end", out_tuser, want.frame_end);
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == REG_IMAGE_WIDTH) model_width = cfg_wr_data[WIDTH_W-1:0];
        else model_height = cfg_wr_data;
        restart_frame();
      end else if (in_tvalid && in_tready) begin
        predict_pixel(in_tdata);
      end
    end
  end

  always @(negedge clk)
    out_tready <= !hold_active && (quiet || $urandom_range(99) >= 21);

  // Long receiver hold-off, counted here so the sender keeps offering pixels.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active = 1'b0;
        hold_req = 1'b0;
      end
    end
  end

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random_pixels(input int unsigned n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_glyphs.size() != 0) @(posedge clk);
    // A pixel that closes no window may still be in the pipeline.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // Reset sizes of 640 x 480, one full band without any idling.
  task automatic test_reset_defaults();
    quiet = 1'b1;
    send_random_pixels(4 * 640);
    quiet = 1'b0;
  endtask

  task automatic test_edge_cases();
    // Zero sizes act as one pixel: every pixel closes a frame.
    set_frame(0, 0);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd15);
    send_pixel(8'd16);
    send_pixel(8'd240);
    send_pixel(8'd128);
    // Even last column and a last row that falls inside a band.
    set_frame(3, 5);
    for (int i = 0; i < 15; i++) send_pixel(i[0] ? 8'd255 : 8'd0);
    set_frame(1, 1);
    send_pixel(8'd255);
    send_pixel(8'd0);
  endtask

  // Width register all ones, upper data bits set: clamps to the widest row.
  task automatic test_widest_row();
    set_frame('1, 1);
    send_random_pixels(MAX_WIDTH);
  endtask

  // Height register all ones clamps to the tallest frame; run past its end.
  task automatic test_tallest_column();
    set_frame(1, '1);
    send_random_pixels(MAX_HEIGHT + 3);
  endtask

  task automatic test_output_stall();
    set_frame(64, 4);
    hold_req = 1'b1;
    send_random_pixels(256);
  endtask

  task automatic test_random_frames();
    int unsigned sent, w, h, n, frame_px, pick;
    logic [CFG_DATA_W-1:0] w_data, h_data;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      pick = $urandom_range(99);
      if (pick < 70) w_data = $urandom_range(1, 20);
      else if (pick < 80) w_data = $urandom_range(21, 80);
      else if (pick < 88) w_data = 0;
      else if (pick < 94) w_data = $urandom_range(1025, 2047);
      else w_data = 2;
      if ($urandom_range(9) == 0) w_data[CFG_DATA_W-1:WIDTH_W] = $urandom_range(3);
      pick = $urandom_range(99);
      if (pick < 75) h_data = $urandom_range(1, 12);
      else if (pick < 85) h_data = 0;
      else h_data = $urandom_range(13, 8191);

      // Sometimes only the width changes, which restarts the frame anyway.
      if ($urandom_range(4) == 0) write_reg(REG_IMAGE_WIDTH, w_data);
      else set_frame(w_data, h_data);

      w = active_width(model_width);
      h = active_height(model_height);
      frame_px = w * h;
      n = frame_px * $urandom_range(1, 3);
      if ($urandom_range(9) < 3) n = $urandom_range(1, n);
      if (n > 400) n = $urandom_range(1, 400);
      send_random_pixels(n);
      sent += n;
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_edge_cases();
    test_widest_row();
    test_tallest_column();
    test_output_stall();
    test_random_frames();

    wait_drained();
    if (error_count == 0) $display("PASS grayscale_block_mean_to_glyph");
    else $display("FAIL grayscale_block_mean_to_glyph");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gbm_pkg.sv
rtl/gbm_ram.sv
rtl/gbm_ctrl.sv
rtl/gbm_accum.sv
rtl/gbm_quant.sv
rtl/grayscale_block_mean_to_glyph.sv
bench/testbench.sv
